### design/stereo_dual_shelf_biquad_eq_assert.svh
// Assertion macros shared by the equalizer RTL
`ifndef STEREO_DUAL_SHELF_BIQUAD_EQ_ASSERT_SVH
`define STEREO_DUAL_SHELF_BIQUAD_EQ_ASSERT_SVH

// cond and expr hold on the same edge
`define SDEQ_ASSERT_SAME(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond implies expr on the following edge
`define SDEQ_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### design/sdeq_pkg.sv
// Shared types and constants for the stereo shelving equaliser
package sdeq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 21;
    localparam int COEF_FRAC_BITS = 14;
    localparam int MIX_BITS       = 17;
    localparam int MIX_SHIFT      = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int FF_BITS        = 3 * COEF_BITS;
    localparam int FB_BITS        = 2 * COEF_BITS;
    localparam int CFG_DATA_BITS  = FF_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int STAGES         = 4;
    localparam int STAGE_BITS     = 2;
    localparam int HIST_BITS      = 4 * SAMPLE_BITS;

    localparam logic [MIX_BITS-1:0] MIX_ONE = MIX_BITS'(65536);
    localparam logic [FF_BITS-1:0]  FF_RESET = FF_BITS'(16384);

    localparam logic signed [ACC_BITS-1:0] HALF_COEF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] HALF_MIX  = ACC_BITS'(1) << (MIX_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_HI    = ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO    = ~SAT_HI;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW_FF,
        REG_LOW_FB,
        REG_HIGH_FF,
        REG_HIGH_FB,
        REG_WET_MIX
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sample_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } sample_out_t;

    // sequencer to MAC unit
    typedef struct packed {
        logic mul_en;
        logic neg;
        logic clear;
        logic acc_en;
        logic mix_shift;
    } mac_ctrl_t;

endpackage

### design/sdeq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module sdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sdeq_mac.sv
// Shared multiply-accumulate unit with rounding and saturation
module sdeq_mac (
    input  logic                clk,
    input  sdeq_pkg::mac_ctrl_t ctrl,
    input  sdeq_pkg::sample_t   a,
    input  sdeq_pkg::coef_t     b,
    output sdeq_pkg::sample_t   result
);

    logic signed [sdeq_pkg::PROD_BITS-1:0] prod_reg;
    logic                                  neg_reg;
    logic signed [sdeq_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [sdeq_pkg::ACC_BITS-1:0]  prod_ext;
    logic signed [sdeq_pkg::ACC_BITS-1:0]  rnd;
    logic signed [sdeq_pkg::ACC_BITS-1:0]  shifted;

    assign prod_ext = sdeq_pkg::ACC_BITS'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= sdeq_pkg::PROD_BITS'(a) * sdeq_pkg::PROD_BITS'(b);
            neg_reg  <= ctrl.neg;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    // round half up, then floor shift
    always_comb
    begin
        if (ctrl.mix_shift)
        begin
            rnd     = acc_reg + sdeq_pkg::HALF_MIX;
            shifted = rnd >>> sdeq_pkg::MIX_SHIFT;
        end
        else
        begin
            rnd     = acc_reg + sdeq_pkg::HALF_COEF;
            shifted = rnd >>> sdeq_pkg::COEF_FRAC_BITS;
        end
        if (shifted > sdeq_pkg::SAT_HI)
        begin
            result = sdeq_pkg::SAT_HI[sdeq_pkg::SAMPLE_BITS-1:0];
        end
        else if (shifted < sdeq_pkg::SAT_LO)
        begin
            result = sdeq_pkg::SAT_LO[sdeq_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            result = shifted[sdeq_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

### design/stereo_dual_shelf_biquad_eq.sv
// A sample is taken only in the idle state, so the next waits until the last result is loaded.
// Each of the four biquad stages does a history read, five products through the single
// shared multiplier plus a final add, and a history write back. Mixes blend dry and wet.
// Filter history sits in a 4-entry RAM, one word per stage; entries not yet written read as zero.
// rst_n (async, active low) clears history flags and sequencer, loads default settings.
module stereo_dual_shelf_biquad_eq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  sdeq_pkg::sample_in_t                   sample,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output sdeq_pkg::sample_out_t                  result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sdeq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sdeq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_WRITE,
        ST_MIX,
        ST_MIXOUT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        T_B0,
        T_B1,
        T_B2,
        T_A1,
        T_A2,
        T_SUM
    } term_t;

    state_t                                state_reg;
    term_t                                 term_reg;
    logic [sdeq_pkg::STAGE_BITS-1:0]       stage_reg;
    logic [sdeq_pkg::STAGES-1:0]           valid_reg;
    logic                                  hvalid_reg;
    logic                                  result_valid_reg;

    logic [sdeq_pkg::FF_BITS-1:0]          low_ff_reg;
    logic [sdeq_pkg::FB_BITS-1:0]          low_fb_reg;
    logic [sdeq_pkg::FF_BITS-1:0]          high_ff_reg;
    logic [sdeq_pkg::FB_BITS-1:0]          high_fb_reg;
    logic [sdeq_pkg::MIX_BITS-1:0]         wet_mix_reg;

    sdeq_pkg::sample_in_t                  in_reg;
    sdeq_pkg::sample_t                     x_reg;
    sdeq_pkg::sample_t                     wet_reg;
    sdeq_pkg::sample_t                     left_res_reg;
    sdeq_pkg::sample_t                     right_res_reg;
    sdeq_pkg::sample_out_t                 result_reg;

    logic [sdeq_pkg::HIST_BITS-1:0]        ram_rdata;
    logic [sdeq_pkg::HIST_BITS-1:0]        hist;
    logic [sdeq_pkg::HIST_BITS-1:0]        wr_hist;
    sdeq_pkg::sample_t                     h_x1;
    sdeq_pkg::sample_t                     h_x2;
    sdeq_pkg::sample_t                     h_y1;
    sdeq_pkg::sample_t                     h_y2;
    logic [sdeq_pkg::FF_BITS-1:0]          ff_sel;
    logic [sdeq_pkg::FB_BITS-1:0]          fb_sel;
    logic [sdeq_pkg::MIX_BITS-1:0]         mix_eff;
    logic [sdeq_pkg::MIX_BITS-1:0]         mix_dry;
    logic                                  load_result;
    logic                                  ram_we;
    logic                                  ram_re;

    sdeq_pkg::mac_ctrl_t                   mac_ctrl;
    sdeq_pkg::sample_t                     mac_a;
    sdeq_pkg::coef_t                       mac_b;
    sdeq_pkg::sample_t                     mac_y;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // history word layout: {y2, y1, x2, x1}; unwritten entries read as zero
    assign hist = hvalid_reg ? ram_rdata : '0;
    assign h_x1 = hist[0*sdeq_pkg::SAMPLE_BITS +: sdeq_pkg::SAMPLE_BITS];
    assign h_x2 = hist[1*sdeq_pkg::SAMPLE_BITS +: sdeq_pkg::SAMPLE_BITS];
    assign h_y1 = hist[2*sdeq_pkg::SAMPLE_BITS +: sdeq_pkg::SAMPLE_BITS];
    assign h_y2 = hist[3*sdeq_pkg::SAMPLE_BITS +: sdeq_pkg::SAMPLE_BITS];
    assign wr_hist = {h_y1, mac_y, h_x1, x_reg};

    assign ff_sel  = stage_reg[0] ? high_ff_reg : low_ff_reg;
    assign fb_sel  = stage_reg[0] ? high_fb_reg : low_fb_reg;
    assign mix_eff = (wet_mix_reg > sdeq_pkg::MIX_ONE) ? sdeq_pkg::MIX_ONE : wet_mix_reg;
    assign mix_dry = sdeq_pkg::MIX_ONE - mix_eff;

    assign load_result = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign ram_re      = (state_reg == ST_READ);
    assign ram_we      = (state_reg == ST_WRITE);

    // each stage entry is read and written back inside its own stage slot,
    // so accesses to one entry never overlap
    sdeq_ram #(
        .WIDTH (sdeq_pkg::HIST_BITS),
        .DEPTH (sdeq_pkg::STAGES)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (stage_reg),
        .wr_data (wr_hist),
        .rd_en   (ram_re),
        .rd_addr (stage_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        case (state_reg)
            ST_MAC:
            begin
                mac_ctrl.mul_en = (term_reg != T_SUM);
                mac_ctrl.neg    = (term_reg == T_A1) || (term_reg == T_A2);
                mac_ctrl.clear  = (term_reg == T_B0);
                mac_ctrl.acc_en = (term_reg != T_B0);
                case (term_reg)
                    T_B0:
                    begin
                        mac_a = x_reg;
                        mac_b = ff_sel[0*sdeq_pkg::COEF_BITS +: sdeq_pkg::COEF_BITS];
                    end
                    T_B1:
                    begin
                        mac_a = h_x1;
                        mac_b = ff_sel[1*sdeq_pkg::COEF_BITS +: sdeq_pkg::COEF_BITS];
                    end
                    T_B2:
                    begin
                        mac_a = h_x2;
                        mac_b = ff_sel[2*sdeq_pkg::COEF_BITS +: sdeq_pkg::COEF_BITS];
                    end
                    T_A1:
                    begin
                        mac_a = h_y1;
                        mac_b = fb_sel[0*sdeq_pkg::COEF_BITS +: sdeq_pkg::COEF_BITS];
                    end
                    T_A2:
                    begin
                        mac_a = h_y2;
                        mac_b = fb_sel[1*sdeq_pkg::COEF_BITS +: sdeq_pkg::COEF_BITS];
                    end
                    default:
                    begin
                        mac_a = '0;
                        mac_b = '0;
                    end
                endcase
            end
            ST_MIX:
            begin
                mac_ctrl.mul_en    = (term_reg == T_B0) || (term_reg == T_B1);
                mac_ctrl.clear     = (term_reg == T_B0);
                mac_ctrl.acc_en    = (term_reg != T_B0);
                mac_ctrl.mix_shift = 1'b1;
                if (term_reg == T_B0)
                begin
                    mac_a = stage_reg[1] ? in_reg.right_in : in_reg.left_in;
                    mac_b = sdeq_pkg::COEF_BITS'(mix_dry);
                end
                else
                begin
                    mac_a = wet_reg;
                    mac_b = sdeq_pkg::COEF_BITS'(mix_eff);
                end
            end
            ST_MIXOUT:
            begin
                mac_ctrl.mix_shift = 1'b1;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    sdeq_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .a      (mac_a),
        .b      (mac_b),
        .result (mac_y)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_ff_reg  <= sdeq_pkg::FF_RESET;
            low_fb_reg  <= '0;
            high_ff_reg <= sdeq_pkg::FF_RESET;
            high_fb_reg <= '0;
            wet_mix_reg <= sdeq_pkg::MIX_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sdeq_pkg::REG_LOW_FF:  low_ff_reg  <= cfg_data;
                sdeq_pkg::REG_LOW_FB:  low_fb_reg  <= cfg_data[sdeq_pkg::FB_BITS-1:0];
                sdeq_pkg::REG_HIGH_FF: high_ff_reg <= cfg_data;
                sdeq_pkg::REG_HIGH_FB: high_fb_reg <= cfg_data[sdeq_pkg::FB_BITS-1:0];
                sdeq_pkg::REG_WET_MIX: wet_mix_reg <= cfg_data[sdeq_pkg::MIX_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            term_reg         <= T_B0;
            stage_reg        <= '0;
            valid_reg        <= '0;
            hvalid_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace one that transfers on the same edge
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        stage_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    hvalid_reg <= valid_reg[stage_reg];
                    term_reg   <= T_B0;
                    state_reg  <= ST_MAC;
                end
                ST_MAC:
                begin
                    if (term_reg == T_SUM)
                    begin
                        state_reg <= ST_WRITE;
                    end
                    else
                    begin
                        term_reg <= term_t'(term_reg + 3'd1);
                    end
                end
                ST_WRITE:
                begin
                    valid_reg[stage_reg] <= 1'b1;
                    term_reg             <= T_B0;
                    if (stage_reg[0])
                    begin
                        state_reg <= ST_MIX;
                    end
                    else
                    begin
                        stage_reg <= stage_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_MIX:
                begin
                    if (term_reg == T_B2)
                    begin
                        state_reg <= ST_MIXOUT;
                    end
                    else
                    begin
                        term_reg <= term_t'(term_reg + 3'd1);
                    end
                end
                ST_MIXOUT:
                begin
                    if (stage_reg[1])
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        stage_reg <= stage_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (load_result)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // sample and result datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample_valid)
        begin
            in_reg <= sample;
            x_reg  <= sample.left_in;
        end
        if (state_reg == ST_WRITE)
        begin
            if (stage_reg[0])
            begin
                wet_reg <= mac_y;
            end
            else
            begin
                x_reg <= mac_y;
            end
        end
        if (state_reg == ST_MIXOUT)
        begin
            if (stage_reg[1])
            begin
                right_res_reg <= mac_y;
            end
            else
            begin
                left_res_reg <= mac_y;
                x_reg        <= in_reg.right_in;
            end
        end
        if (load_result)
        begin
            result_reg.left_out  <= left_res_reg;
            result_reg.right_out <= right_res_reg;
        end
    end

`include "stereo_dual_shelf_biquad_eq_assert.svh"

    `SDEQ_ASSERT_NEXT(a_accept_starts, sample_valid && !sample_stall,
        state_reg == ST_READ && stage_reg == '0, "sample transfer did not start stage 0 read")
    `SDEQ_ASSERT_SAME(a_result_from_done, $rose(result_valid),
        $past(state_reg == ST_DONE), "result raised outside done state")
    `SDEQ_ASSERT_NEXT(a_hist_flags_keep, 1'b1,
        $countones(valid_reg) >= $past($countones(valid_reg)), "history valid flag lost")
    `SDEQ_ASSERT_SAME(a_write_after_read, ram_we,
        hvalid_reg == valid_reg[stage_reg] || !hvalid_reg, "history write back out of order")

endmodule

### tb/stereo_dual_shelf_biquad_eq_tb.sv
// Self-checking testbench for the stereo two-band shelving equaliser
`timescale 1ns / 100ps

module stereo_dual_shelf_biquad_eq_tb;
    import sdeq_pkg::*;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 78;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_REPORTS  = 20;
    localparam int FIRST_SPARE  = int'(REG_WET_MIX) + 1;
    localparam int LAST_INDEX   = (1 << CFG_INDEX_BITS) - 1;

    localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam sample_t ALT_A = 24'h555555;
    localparam sample_t ALT_B = 24'hAAAAAA;
    localparam coef_t COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam coef_t COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam coef_t COEF_UNITY = coef_t'(1 << COEF_FRAC_BITS);
    localparam logic [CFG_DATA_BITS-1:0] ALL_ONES  = '1;
    // junk above the register width, must be dropped by the block
    localparam logic [CFG_DATA_BITS-1:0] ABOVE_FB  = {21'h15A5A5, 42'd0};
    localparam logic [CFG_DATA_BITS-1:0] ABOVE_MIX = {46'h2AAA_5555_1234, 17'd0};

    typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;
    typedef enum int {CFG_TAME, CFG_RAW, CFG_CORNER} setting_style_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        sample_in_t                pair;
        bit                        typed;
        sample_out_t               want;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_in_t                sample = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b1;
    sample_out_t               result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // shadow of the block's registers and filter history
    logic [FF_BITS-1:0]  lo_ff = FF_RESET;
    logic [FB_BITS-1:0]  lo_fb = '0;
    logic [FF_BITS-1:0]  hi_ff = FF_RESET;
    logic [FB_BITS-1:0]  hi_fb = '0;
    logic [MIX_BITS-1:0] mix_setting = MIX_ONE;
    sample_t             hist [STAGES][4];   // per stage {x1, x2, y1, y2}

    sample_out_t eq_outputs_due [$];
    row_t        dir_rows [$];

    bit calm = 1'b0;
    bit cfg_open = 1'b0;
    int rx_wait = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int writes_done = 0;
    int settings = 0;
    int mismatches = 0;
    int orphans = 0;
    int reports = 0;

    stereo_dual_shelf_biquad_eq dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int s = 0; s < STAGES; s++)
            for (int k = 0; k < 4; k++)
                hist[s][k] = '0;
    end

    // ---------------- predictor ----------------

    function automatic sample_t clip(longint v);
        if (v > longint'(S_MAX))
            return S_MAX;
        if (v < longint'(S_MIN))
            return S_MIN;
        return sample_t'(v);
    endfunction

    function automatic sample_t run_biquad(int st, logic [FF_BITS-1:0] ff,
                                           logic [FB_BITS-1:0] fb, sample_t x);
        coef_t   b0, b1, b2, a1, a2;
        longint  acc;
        sample_t y;
        b0 = ff[COEF_BITS-1:0];
        b1 = ff[2*COEF_BITS-1:COEF_BITS];
        b2 = ff[3*COEF_BITS-1:2*COEF_BITS];
        a1 = fb[COEF_BITS-1:0];
        a2 = fb[2*COEF_BITS-1:COEF_BITS];
        acc = longint'(b0) * longint'(x)
            + longint'(b1) * longint'(hist[st][0])
            + longint'(b2) * longint'(hist[st][1])
            - longint'(a1) * longint'(hist[st][2])
            - longint'(a2) * longint'(hist[st][3]);
        y = clip((acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
        hist[st][1] = hist[st][0];
        hist[st][0] = x;
        hist[st][3] = hist[st][2];
        hist[st][2] = y;
        return y;
    endfunction

    function automatic sample_t blend(sample_t dry, sample_t wet);
        longint m, acc;
        m = (mix_setting > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_setting);
        acc = longint'(dry) * (longint'(MIX_ONE) - m) + longint'(wet) * m;
        return clip((acc + (longint'(1) << (MIX_SHIFT - 1))) >>> MIX_SHIFT);
    endfunction

    // stages: 0 low left, 1 high left, 2 low right, 3 high right
    function automatic sample_out_t equalise_pair(sample_in_t p);
        sample_t     lw, rw;
        sample_out_t o;
        lw = run_biquad(0, lo_ff, lo_fb, p.left_in);
        lw = run_biquad(1, hi_ff, hi_fb, lw);
        rw = run_biquad(2, lo_ff, lo_fb, p.right_in);
        rw = run_biquad(3, hi_ff, hi_fb, rw);
        o.left_out  = blend(p.left_in, lw);
        o.right_out = blend(p.right_in, rw);
        return o;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            REG_LOW_FF:  lo_ff = d[FF_BITS-1:0];
            REG_LOW_FB:  lo_fb = d[FB_BITS-1:0];
            REG_HIGH_FF: hi_ff = d[FF_BITS-1:0];
            REG_HIGH_FB: hi_fb = d[FB_BITS-1:0];
            REG_WET_MIX: mix_setting = d[MIX_BITS-1:0];
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [CFG_DATA_BITS-1:0] pack3(coef_t b0, coef_t b1, coef_t b2);
        return CFG_DATA_BITS'({b2, b1, b0});
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pack2(coef_t a1, coef_t a2);
        return CFG_DATA_BITS'({a2, a1});
    endfunction

    function automatic void add_write(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] d);
        row_t row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = d;
        row.pair = '0;
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(sample_t l, sample_t r, bit typed,
                                      sample_t el, sample_t er);
        row_t row;
        row.kind = ROW_PAIR;
        row.idx = '0;
        row.data = '0;
        row.pair.left_in = l;
        row.pair.right_in = r;
        row.typed = typed;
        row.want.left_out = el;
        row.want.right_out = er;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_pair(sample_t l, sample_t r);
        add_known(l, r, 1'b0, '0, '0);
    endfunction

    function automatic coef_t rand_coef(int span);
        return coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic coef_t corner_coef();
        case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return COEF_UNITY;
            default: return -COEF_UNITY;
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] draw_reg_value(int idx, setting_style_t style);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (style == CFG_RAW)
            return raw[CFG_DATA_BITS-1:0];
        case (idx)
            REG_LOW_FF, REG_HIGH_FF:
                if (style == CFG_TAME)
                    return pack3(rand_coef(32768), rand_coef(32768), rand_coef(16384));
                else
                    return pack3(corner_coef(), corner_coef(), corner_coef());
            REG_LOW_FB, REG_HIGH_FB:
                if (style == CFG_TAME)
                    return pack2(rand_coef(30000), rand_coef(14000));
                else
                    return pack2(corner_coef(), corner_coef());
            default:
                if (style == CFG_TAME)
                    return CFG_DATA_BITS'($urandom_range(0, int'(MIX_ONE)));
                else
                    case ($urandom_range(0, 5))
                        0: return '0;
                        1: return CFG_DATA_BITS'(1);
                        2: return CFG_DATA_BITS'(MIX_ONE) - 1'b1;
                        3: return CFG_DATA_BITS'(MIX_ONE);
                        4: return CFG_DATA_BITS'(MIX_ONE) + 1'b1;
                        default: return CFG_DATA_BITS'({MIX_BITS{1'b1}});
                    endcase
        endcase
    endfunction

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1, 2: return sample_t'(int'($urandom_range(0, 8192)) - 4096);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ---------------- channel tasks ----------------

    task automatic cfg_close();
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        cfg_close();
        @(posedge clk);
        while (eq_outputs_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_open = 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, d);
        writes_done++;
    endtask

    task automatic send_pair(sample_in_t p, bit typed, sample_out_t want);
        int          gap;
        sample_out_t model;
        gap = calm ? 0 : $urandom_range(0, 8);
        cfg_close();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= p;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        // history advances even when the expectation is typed in
        model = equalise_pair(p);
        eq_outputs_due.push_back(typed ? want : model);
        items_sent++;
    endtask

    // ---------------- result side ----------------

    always @(posedge clk)
    begin
        sample_out_t want;
        if (!rst_n)
            rx_wait = calm ? 0 : $urandom_range(0, 8);
        else if (result_valid && !result_stall)
        begin
            if (eq_outputs_due.size() == 0)
            begin
                orphans++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, result);
            end
            else
            begin
                want = eq_outputs_due.pop_front();
                results_seen++;
                if (result.left_out !== want.left_out)
                begin
                    mismatches++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: left_out expected %0d, got %0d",
                                 $time, want.left_out, result.left_out);
                end
                if (result.right_out !== want.right_out)
                begin
                    mismatches++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: right_out expected %0d, got %0d",
                                 $time, want.right_out, result.right_out);
                end
            end
            rx_wait = calm ? 0 : $urandom_range(0, 8);
        end
        else if (rx_wait != 0 && result_valid)
            rx_wait--;
        // stall is raised ahead of the next result so it bites while that result is offered
        result_stall <= (rx_wait != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("** stereo_dual_shelf_biquad_eq: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------- sequence ----------------

    initial
    begin
        setting_style_t style;
        sample_in_t     p;

        // reset settings are pass-through: out equals in
        add_known(0, 0, 1'b1, 0, 0);
        add_known(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
        add_known(S_MIN, S_MAX, 1'b1, S_MIN, S_MAX);
        add_known(1, -1, 1'b1, 1, -1);
        add_known(ALT_A, ALT_B, 1'b1, ALT_A, ALT_B);
        // mix above one clamps to fully wet, still pass-through
        add_write(REG_WET_MIX, ALL_ONES);
        add_known(S_MAX, ALT_B, 1'b1, S_MAX, ALT_B);
        add_known(-1, S_MIN, 1'b1, -1, S_MIN);
        // spare indexes must not touch any register
        for (int i = FIRST_SPARE; i <= LAST_INDEX; i++)
            add_write(CFG_INDEX_BITS'(i), ALL_ONES);
        add_known(ALT_A, 1, 1'b1, ALT_A, 1);
        // fully dry: wild filter must not reach the output
        add_write(REG_LOW_FF, pack3(COEF_MAX, COEF_MIN, COEF_MAX));
        add_write(REG_WET_MIX, '0);
        add_known(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
        add_known(S_MIN, S_MAX, 1'b1, S_MIN, S_MAX);
        // stage saturation
        add_write(REG_WET_MIX, CFG_DATA_BITS'(MIX_ONE));
        add_pair(S_MAX, S_MIN);
        add_pair(S_MIN, S_MAX);
        add_pair(0, 0);
        add_write(REG_LOW_FB, pack2(COEF_MIN, COEF_MAX) | ABOVE_FB);
        add_write(REG_HIGH_FF, pack3(COEF_MIN, '0, COEF_MAX));
        add_write(REG_HIGH_FB, pack2(COEF_MAX, COEF_MIN) | ABOVE_FB);
        add_write(REG_WET_MIX, CFG_DATA_BITS'(MIX_ONE >> 1) | ABOVE_MIX);
        add_pair(S_MAX, S_MAX);
        add_pair(S_MIN, S_MIN);
        add_pair(ALT_A, ALT_B);
        add_pair(0, 1);
        add_write(REG_WET_MIX, CFG_DATA_BITS'(1));
        add_pair(S_MAX, S_MIN);
        add_pair(S_MIN, S_MAX);
        add_write(REG_WET_MIX, CFG_DATA_BITS'(MIX_ONE) - 1'b1);
        add_pair(1, -1);
        add_pair(S_MAX, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings = 1;
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_WRITE)
            begin
                if (k == 0 || dir_rows[k-1].kind != ROW_WRITE)
                begin
                    drain_results();
                    settings++;
                end
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end
            else
                send_pair(dir_rows[k].pair, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            settings++;
            style = setting_style_t'(ph % 3);
            for (int r = 0; r <= int'(REG_WET_MIX); r++)
                if (ph == 0 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_INDEX_BITS'(r), draw_reg_value(r, style));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(FIRST_SPARE, LAST_INDEX)),
                          CFG_DATA_BITS'({$urandom, $urandom}));
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold off the sender until the pipeline is empty
                if (i == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    drain_results();
                p.left_in = draw_sample();
                p.right_in = draw_sample();
                send_pair(p, 1'b0, '0);
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d stereo pairs over %0d filter settings, %0d register writes.",
                 items_sent, settings, writes_done);
        $display("%0d outputs compared, %0d field mismatches, %0d unexpected transfers.",
                 results_seen, mismatches, orphans);
        if (mismatches == 0 && orphans == 0 && eq_outputs_due.size() == 0)
            $display("** stereo_dual_shelf_biquad_eq: PASSED **");
        else
            $display("** stereo_dual_shelf_biquad_eq: FAILED **");
        $finish;
    end

endmodule
